// ===== rtl/clsr_pkg.sv =====
package clsr_pkg;

    // Field and product widths
    localparam int VAL_W          = 31;
    localparam int PROD_W         = 47;

    // Generator constants
    localparam logic [30:0] MOD1         = 31'd2147483563;
    localparam logic [30:0] MOD2         = 31'd2147483399;
    localparam logic [15:0] MUL1         = 16'd40014;
    localparam logic [15:0] MUL2         = 16'd40692;
    localparam logic [7:0]  FOLD1        = 8'd85;    // 2^31 - MOD1
    localparam logic [7:0]  FOLD2        = 8'd249;   // 2^31 - MOD2
    localparam logic [30:0] RANGE_TOP    = 31'd2147483562;
    localparam logic [30:0] SECOND_RESET = 31'd123456789;

    // Warm-up steps run beyond the table depth on a reseed
    localparam int WARMUP         = 8;
    localparam int DEF_TABLE_SIZE = 32;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_WMUL,
        ST_WRED,
        ST_MUL,
        ST_RED,
        ST_RD,
        ST_UPD
    } state_t;

    // Datapath commands
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_SEED,
        CMD_WMUL,
        CMD_WRED,
        CMD_MUL,
        CMD_RED,
        CMD_RD,
        CMD_UPD
    } cmd_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic s1_zero;
        logic j_zero;
        logic out_free;
    } dp_status_t;

    // Reduce a product modulo 2^31 - fold; the folded sum stays below twice the modulus
    function automatic logic [30:0] mod_fold(input logic [46:0] prod,
                                             input logic [7:0]  fold,
                                             input logic [30:0] modulus);
        logic [31:0] sum;
        sum = {1'b0, prod[30:0]} + (32'(prod[46:31]) * 32'(fold));
        if (sum >= {1'b0, modulus}) begin
            sum = sum - {1'b0, modulus};
        end
        return sum[30:0];
    endfunction

endpackage

// ===== rtl/clsr_ctrl.sv =====
module clsr_ctrl
    import clsr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       restart,
    input  dp_status_t status,
    output logic       in_ready,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   need_seed;

    assign need_seed = restart || status.s1_zero;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = need_seed ? ST_SEED : ST_RED;
                end
            end
            ST_SEED: state_next = ST_WMUL;
            ST_WMUL: state_next = ST_WRED;
            ST_WRED: state_next = status.j_zero ? ST_MUL : ST_WMUL;
            ST_MUL:  state_next = ST_RED;
            ST_RED:  state_next = ST_RD;
            ST_RD:   state_next = ST_UPD;
            ST_UPD: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: multiply starts in the accept cycle when no reseed is due
    always_comb begin
        in_ready = 1'b0;
        cmd      = CMD_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd = need_seed ? CMD_SEED : CMD_MUL;
                end
            end
            ST_SEED: cmd = CMD_NONE;
            ST_WMUL: cmd = CMD_WMUL;
            ST_WRED: cmd = CMD_WRED;
            ST_MUL:  cmd = CMD_MUL;
            ST_RED:  cmd = CMD_RED;
            ST_RD:   cmd = CMD_RD;
            ST_UPD:  cmd = status.out_free ? CMD_UPD : CMD_NONE;
            default: cmd = CMD_NONE;
        endcase
    end

endmodule

// ===== rtl/clsr_dp.sv =====
module clsr_dp
    import clsr_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  logic              cfg_we,
    input  logic [VAL_W-1:0]  cfg_wdata,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [VAL_W-1:0]  m_value,
    output dp_status_t        status
);

    localparam int          IDXW     = $clog2(TABLE_SIZE);
    localparam int          JW       = $clog2(TABLE_SIZE + WARMUP);
    localparam int unsigned NDIV_I   = 1 + RANGE_TOP / TABLE_SIZE;
    localparam logic [30:0] NDIV     = 31'(NDIV_I);
    localparam logic [63:0] RECIP_L  = 64'h1_0000_0000 / 64'(NDIV_I);
    localparam int          RECIP_W  = $clog2(RECIP_L + 64'd1);
    localparam int          QP_W     = VAL_W + RECIP_W;
    localparam int          Q0W      = QP_W - 32;
    localparam int          QW       = Q0W + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic [VAL_W-1:0]  seed_reg;
    logic [VAL_W-1:0]  s1_reg;
    logic [VAL_W-1:0]  s2_reg;
    logic [VAL_W-1:0]  sel_reg;
    logic [PROD_W-1:0] p1_reg;
    logic [PROD_W-1:0] p2_reg;
    logic [Q0W-1:0]    q0_reg;
    logic [IDXW-1:0]   idx_reg;
    logic [JW-1:0]     j_reg;
    logic [VAL_W-1:0]  rd_reg;
    logic [VAL_W-1:0]  out_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  mem [TABLE_SIZE];

    logic [VAL_W-1:0]  seed_eff;
    logic [VAL_W-1:0]  s1_red;
    logic [VAL_W-1:0]  s2_red;
    logic [QP_W-1:0]   qprod;
    logic [31:0]       qmul;
    logic [31:0]       rem;
    logic              corr;
    logic [QW-1:0]     q_sum;
    logic [IDXW-1:0]   idx_next;
    logic [31:0]       diff;
    logic [31:0]       diff_adj;
    logic [VAL_W-1:0]  draw;
    logic              warm_in_table;
    logic              mem_we;
    logic [IDXW-1:0]   mem_addr;
    logic [VAL_W-1:0]  mem_wdata;

    // Seed of zero runs as one
    assign seed_eff = (seed_reg == '0) ? VAL_W'(1) : seed_reg;

    // Modular reduction of the registered products
    assign s1_red = mod_fold(p1_reg, FOLD1, MOD1);
    assign s2_red = mod_fold(p2_reg, FOLD2, MOD2);

    // Table index: reciprocal estimate, then one correction step
    assign qprod    = QP_W'(sel_reg) * QP_W'(RECIP);
    assign qmul     = 32'(q0_reg) * 32'(NDIV);
    assign rem      = {1'b0, sel_reg} - qmul;
    assign corr     = (rem >= {1'b0, NDIV});
    assign q_sum    = QW'(q0_reg) + QW'(corr);
    assign idx_next = (q_sum >= QW'(TABLE_SIZE)) ? IDXW'(TABLE_SIZE - 1) : q_sum[IDXW-1:0];

    // Shuffled draw: entry minus second generator, wrapped into range
    assign diff     = {1'b0, rd_reg} - {1'b0, s2_reg};
    assign diff_adj = (diff[31] || diff == '0) ? diff + {1'b0, RANGE_TOP} : diff;
    assign draw     = diff_adj[VAL_W-1:0];

    // Table write port: warm-up fill or refill of the entry just read
    assign warm_in_table = (j_reg < JW'(TABLE_SIZE));
    assign mem_we    = (cmd == CMD_WRED && warm_in_table) || cmd == CMD_UPD;
    assign mem_addr  = (cmd == CMD_UPD) ? idx_reg : j_reg[IDXW-1:0];
    assign mem_wdata = (cmd == CMD_UPD) ? s1_reg : s1_red;

    // Status to controller
    assign status.s1_zero  = (s1_reg == '0);
    assign status.j_zero   = (j_reg == '0);
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_value  = out_reg;

    // Generator state, selector and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= '0;
            s1_reg        <= '0;
            s2_reg        <= SECOND_RESET;
            sel_reg       <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                seed_reg <= cfg_wdata;
            end
            // Raise the output on an update, drop it once taken
            if (cmd == CMD_UPD) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd)
                CMD_SEED: begin
                    s1_reg <= seed_eff;
                    s2_reg <= seed_eff;
                    j_reg  <= JW'(TABLE_SIZE + WARMUP - 1);
                end
                CMD_WRED: begin
                    s1_reg <= s1_red;
                    if (j_reg == '0) begin
                        sel_reg <= s1_red;
                    end else begin
                        j_reg <= j_reg - JW'(1);
                    end
                end
                CMD_RED: begin
                    s1_reg <= s1_red;
                    s2_reg <= s2_red;
                end
                CMD_UPD: begin
                    sel_reg <= draw;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload pipeline registers
    always_ff @(posedge aclk) begin
        unique case (cmd)
            CMD_WMUL: begin
                p1_reg <= PROD_W'(MUL1) * PROD_W'(s1_reg);
            end
            CMD_MUL: begin
                p1_reg <= PROD_W'(MUL1) * PROD_W'(s1_reg);
                p2_reg <= PROD_W'(MUL2) * PROD_W'(s2_reg);
                q0_reg <= qprod[QP_W-1:32];
            end
            CMD_RED: begin
                idx_reg <= idx_next;
            end
            CMD_UPD: begin
                out_reg <= draw;
            end
            default: begin
            end
        endcase
    end

    // Shuffle table: one write port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd == CMD_RD) begin
            rd_reg <= mem[idx_reg];
        end
    end

    // Update only when the output register can take the draw
    a_upd_space: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == CMD_UPD |-> (!out_valid_reg || m_tready))
        else $error("update issued while output register is occupied");

    // Presented draw matches the new selector
    a_upd_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == CMD_UPD |=> (out_valid_reg && out_reg == sel_reg))
        else $error("output does not match selector after update");

    // Reduced generators stay below their moduli
    a_red_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd == CMD_RED) |-> (s1_reg < MOD1 && s2_reg < MOD2))
        else $error("generator state out of modulus range");

    // Table read address within depth
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == CMD_RD |-> (32'(idx_reg) < 32'(TABLE_SIZE)))
        else $error("table index out of range");

endmodule

// ===== rtl/combined_lcg_shuffle_rng.sv =====
// Channel     Direction  Handshake          Payload
// s_ (input)  in         s_tvalid/s_tready  s_tdata[0] restart
// m_ (result) out        m_tvalid/m_tready  m_tdata[30:0] random_value
// cfg         in         cfg_we             cfg_wdata[30:0] seed
//
// A normal transaction runs from accept to the next accept through four steps: multiply,
// reduce and index, table read, table update; the registered product and the
// registered table read set this.
// A reseed adds the seed load, the registered multiply/reduce steps of the warm-up loop
// and the separate multiply step that follows it.
// Reset is synchronous, active low; the first transaction after reset reseeds.
// The result sits in an output register; a stalled m_ side holds only the update step.
module combined_lcg_shuffle_rng
    import clsr_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [0] restart, [7:1] zero
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,    // [30:0] random_value, [31] zero
    input  logic             cfg_we,
    input  logic [VAL_W-1:0] cfg_wdata
);

    cmd_t             cmd;
    dp_status_t       status;
    logic [VAL_W-1:0] m_value;

    // Sequencer
    clsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .restart  (s_tdata[0]),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // Generators, shuffle table and output register
    clsr_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_value   (m_value),
        .status    (status)
    );

    assign m_tdata = {1'b0, m_value};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import clsr_pkg::*;

    localparam int  TBL        = DEF_TABLE_SIZE;
    localparam int  IDX_W      = $clog2(TBL);
    localparam int  CYCLE_CAP  = 500000;
    localparam int  HOLD_LEN   = 400;
    localparam int  SEG_ITEMS  = 110;
    localparam logic [30:0] NDIV = 31'(1 + RANGE_TOP / TBL);

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'd0;   // [0] restart, [7:1] zero
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [31:0]      m_tdata;            // [30:0] random_value, [31] zero
    logic             cfg_we    = 1'b0;
    logic [VAL_W-1:0] cfg_wdata = '0;

    combined_lcg_shuffle_rng u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock: 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Generator mirror: seed register, both generators, selector and shuffle table
    logic [30:0] seed_reg = '0;
    logic [30:0] gen1     = '0;
    logic [30:0] gen2     = SECOND_RESET;
    logic [30:0] sel      = '0;
    logic [30:0] shuf [TBL];

    logic [30:0] expected_draws [$];
    bit          restart_queue  [$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int err_count    = 0;
    int cycle_count  = 0;
    int hold_reqs    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    function automatic logic [30:0] lcg1_next(input logic [30:0] s);
        longint unsigned p;
        p = 64'(MUL1) * 64'(s);
        return 31'(p % 64'(MOD1));
    endfunction

    function automatic logic [30:0] lcg2_next(input logic [30:0] s);
        longint unsigned p;
        p = 64'(MUL2) * 64'(s);
        return 31'(p % 64'(MOD2));
    endfunction

    // Advance the mirror by one transaction and queue the value it must produce
    task automatic predict_draw(input bit restart);
        logic [30:0]      s;
        logic [30:0]      q;
        logic [IDX_W-1:0] idx;
        longint           diff;
        int               j;
        if (restart || gen1 == 0) begin
            s = (seed_reg == 0) ? 31'd1 : seed_reg;
            gen2 = s;
            for (j = TBL + WARMUP - 1; j >= 0; j--) begin
                s = lcg1_next(s);
                if (j < TBL) shuf[j[IDX_W-1:0]] = s;
            end
            gen1 = s;
            sel  = shuf[0];
        end
        gen1 = lcg1_next(gen1);
        gen2 = lcg2_next(gen2);
        q    = sel / NDIV;
        if (q >= 31'(TBL)) q = 31'(TBL - 1);
        idx  = q[IDX_W-1:0];
        diff = longint'(shuf[idx]) - longint'(gen2);
        if (diff < 1) diff += longint'(RANGE_TOP);
        sel       = 31'(diff);
        shuf[idx] = gen1;
        expected_draws.push_back(sel);
    endtask

    task automatic report_mismatch(input string what, input logic [30:0] got,
                                   input logic [30:0] want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // Driver: predict on each accepted transaction, then offer the next restart flag
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_draw(s_tdata[0]);
            end
            if (!s_tvalid || s_tready) begin
                if (restart_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, restart_queue.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off of the result side, counted here
    always @(posedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
    end

    // Monitor: compare each result transaction with the oldest expected draw
    always @(posedge aclk) begin
        logic [30:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_draws.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[30:0], 31'd0);
            end else begin
                want = expected_draws.pop_front();
                if (m_tdata[30:0] !== want)
                    report_mismatch("random_value", m_tdata[30:0], want);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_seed(input logic [30:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        seed_reg   = v;
    endtask

    // Wait until every queued transaction has gone through and every draw came back
    task automatic drain();
        do @(negedge aclk);
        while (restart_queue.size() != 0 || s_tvalid || expected_draws.size() != 0);
    endtask

    task automatic push_draws(input bit first_restart, input int count, input int pct);
        int k;
        restart_queue.push_back(first_restart);
        for (k = 1; k < count; k++)
            restart_queue.push_back($urandom_range(99) < pct);
    endtask

    logic [30:0] dir_seeds [6] = '{31'd2147483562, 31'd2147483563, 31'd2147483399,
                                   31'h7fffffff, 31'd1, 31'd0};

    initial begin
        int m;
        int k;
        logic [30:0] sd;

        for (k = 0; k < TBL; k++) shuf[k[IDX_W-1:0]] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: unseeded start with the reset seed, then each extreme seed
        push_draws(1'b0, 3, 0);
        restart_queue.push_back(1'b1);
        drain();
        foreach (dir_seeds[i]) begin
            write_seed(dir_seeds[i]);
            restart_queue.push_back(1'b1);
            restart_queue.push_back(1'b0);
            restart_queue.push_back(1'b0);
            drain();
        end

        // Random: three idle profiles, three seed settings each
        for (m = 0; m < 3; m++) begin
            snd_idle_pct = (m == 0) ? 28 : (m == 1) ? 60 : 0;
            rcv_idle_pct = (m == 0) ? 60 : (m == 1) ? 28 : 0;
            for (k = 0; k < 3; k++) begin
                case (k)
                    0:       sd = 31'($urandom_range(int'(RANGE_TOP), 0));
                    1:       sd = (m == 1) ? 31'd0 : RANGE_TOP;
                    default: sd = 31'($urandom);
                endcase
                write_seed(sd);
                push_draws(1'b1, SEG_ITEMS, 4);
                // Stall the result side long enough to back up the input
                if (m == 2 && k == 0) hold_reqs++;
                drain();
            end
        end

        repeat (100) @(posedge aclk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
